// ===== hw/rtl/asbm_pkg.sv =====
// ----------------------------------------------------------------------------
// asbm_pkg: shared types and constants of the animated square bitmap marker
// Command and result beats, operation and register codes, memory geometry.
// ----------------------------------------------------------------------------
package asbm_pkg;

	// Geometry defaults
	localparam int DEF_MAX_WIDTH_SQUARES  = 128;
	localparam int DEF_MAX_HEIGHT_SQUARES = 128;

	// Bitmap words: one memory entry holds this many squares
	localparam int WORD_BITS = 64;
	localparam int OFS_W     = $clog2(WORD_BITS);

	localparam int DEF_DEPTH  = (DEF_MAX_WIDTH_SQUARES * DEF_MAX_HEIGHT_SQUARES
		+ WORD_BITS - 1) / WORD_BITS;
	localparam int DEF_ADDR_W = (DEF_DEPTH > 1) ? $clog2(DEF_DEPTH) : 1;

	// Configuration port
	localparam int CFG_W     = 8;
	localparam int REG_IDX_W = 1;
	localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 8'd128;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MAP_WIDTH  = 1'b0,
		REG_MAP_HEIGHT = 1'b1
	} reg_idx_t;

	// Operation codes
	typedef enum logic [1:0] {
		OP_MARK     = 2'd0,
		OP_CLASSIFY = 2'd1,
		OP_CLEAR    = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [15:0] tile_left;
		logic signed [15:0] tile_top;
		logic [9:0]         tile_width;
		logic [9:0]         tile_height;
		logic               tile_animated;
	} cmd_t;

	typedef struct packed {
		logic       rejected;
		logic [1:0] done_operation;
	} result_t;

endpackage

// ===== hw/rtl/asbm_bitmap_mem.sv =====
// ----------------------------------------------------------------------------
// asbm_bitmap_mem: square bitmap storage
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module asbm_bitmap_mem #(
	parameter int DEPTH  = asbm_pkg::DEF_DEPTH,
	parameter int ADDR_W = asbm_pkg::DEF_ADDR_W,
	parameter int WORD_W = asbm_pkg::WORD_BITS
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WORD_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WORD_W-1:0] wr_data
);
	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/asbm_walker.sv =====
// ----------------------------------------------------------------------------
// asbm_walker: command sequencer and square walk
// Clips the tile to the map, walks covered squares one per cycle with a
// read-modify-write pipeline into the bitmap memory, sweeps it on clear.
// ----------------------------------------------------------------------------
module asbm_walker #(
	parameter int MAX_W  = asbm_pkg::DEF_MAX_WIDTH_SQUARES,
	parameter int MAX_H  = asbm_pkg::DEF_MAX_HEIGHT_SQUARES,
	parameter int DEPTH  = asbm_pkg::DEF_DEPTH,
	parameter int ADDR_W = asbm_pkg::DEF_ADDR_W
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  asbm_pkg::cmd_t                 cmd,
	input  logic [asbm_pkg::CFG_W-1:0]     map_width,
	input  logic [asbm_pkg::CFG_W-1:0]     map_height,
	output logic                           busy,
	output logic                           fin,
	output asbm_pkg::result_t              res,
	output logic                           rd_en,
	output logic [ADDR_W-1:0]              rd_addr,
	input  logic [asbm_pkg::WORD_BITS-1:0] rd_data,
	output logic                           wr_en,
	output logic [ADDR_W-1:0]              wr_addr,
	output logic [asbm_pkg::WORD_BITS-1:0] wr_data
);
	import asbm_pkg::*;

	localparam int IDX_W   = ADDR_W + OFS_W;
	localparam int DIM_MAX = (MAX_W > MAX_H) ? MAX_W : MAX_H;
	localparam int DIM_W   = $clog2(DIM_MAX + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_CLIP,
		ST_BASE,
		ST_WALK,
		ST_DRAIN,
		ST_CLEAR
	} state_t;

	function automatic logic signed [15:0] div8(input logic signed [15:0] v);
		logic signed [15:0] r;
		r = v[15] ? ((v + 16'sd7) >>> 3) : (v >>> 3);
		return r;
	endfunction

	state_t              state_q;
	cmd_t                cmd_q;
	result_t             res_q;
	logic                fin_q;
	logic                clr_cmd_q;
	logic [ADDR_W-1:0]   clr_q;
	logic                hit_q;

	logic signed [15:0]  x0_q, y0_q;
	logic [DIM_W-1:0]    xs_q, xe_q, ys_q, ye_q, x_q, y_q;
	logic [IDX_W-1:0]    base_q;

	logic                valid_s1;
	logic [ADDR_W-1:0]   word_s1;
	logic [OFS_W-1:0]    bit_s1;

	logic                wr_valid_q;
	logic [ADDR_W-1:0]   wr_addr_q;
	logic [WORD_BITS-1:0] wr_data_q;

	logic [DIM_W-1:0]    mw, mh, x_nxt, y_nxt;
	logic                x_last, y_last;
	logic signed [15:0]  w8, h8, mw_s, mh_s, xe_raw, ye_raw, xs_c, xe_c, ys_c, ye_c;
	logic                clip_empty;
	logic [IDX_W-1:0]    idx;
	logic [WORD_BITS-1:0] rd_word, set_word;
	logic                hit_now, is_mark;
	logic                fin_nxt;

	// Clamp map size to the storage geometry
	assign mw = (16'(map_width) > 16'(MAX_W)) ? DIM_W'(MAX_W) : DIM_W'(map_width);
	assign mh = (16'(map_height) > 16'(MAX_H)) ? DIM_W'(MAX_H) : DIM_W'(map_height);

	// Clip window in squares, end exclusive
	assign w8     = $signed({9'b0, cmd_q.tile_width[9:3]});
	assign h8     = $signed({9'b0, cmd_q.tile_height[9:3]});
	assign mw_s   = $signed(16'(mw));
	assign mh_s   = $signed(16'(mh));
	assign xe_raw = x0_q + w8;
	assign ye_raw = y0_q + h8;
	assign xs_c   = x0_q[15] ? 16'sd0 : x0_q;
	assign ys_c   = y0_q[15] ? 16'sd0 : y0_q;
	assign xe_c   = (xe_raw > mw_s) ? mw_s : xe_raw;
	assign ye_c   = (ye_raw > mh_s) ? mh_s : ye_raw;
	assign clip_empty = (xe_c <= xs_c) || (ye_c <= ys_c);

	// Walk position
	assign x_nxt  = x_q + DIM_W'(1);
	assign y_nxt  = y_q + DIM_W'(1);
	assign x_last = (x_nxt == xe_q);
	assign y_last = (y_nxt == ye_q);
	assign idx    = base_q + IDX_W'(x_q);

	assign is_mark = (cmd_q.operation == OP_MARK);

	// Finish strobe: immediate answers, empty clip, end of walk, end of clear
	assign fin_nxt = ((state_q == ST_IDLE) && start
			&& ((cmd.operation == OP_MARK) ? !cmd.tile_animated
			: (cmd.operation == OP_CLASSIFY) ? cmd.tile_animated
			: (cmd.operation != OP_CLEAR)))
		|| ((state_q == ST_CLIP) && clip_empty)
		|| (state_q == ST_DRAIN)
		|| ((state_q == ST_CLEAR) && (clr_q == ADDR_W'(DEPTH - 1)) && clr_cmd_q);

	// Stage 1: take the word just written when the same entry is read back
	assign rd_word  = (wr_valid_q && (wr_addr_q == word_s1)) ? wr_data_q : rd_data;
	assign set_word = rd_word | (WORD_BITS'(1) << bit_s1);
	assign hit_now  = valid_s1 && rd_word[bit_s1];

	assign rd_en   = (state_q == ST_WALK);
	assign rd_addr = idx[IDX_W-1:OFS_W];
	assign wr_en   = (state_q == ST_CLEAR) || (valid_s1 && is_mark);
	assign wr_addr = (state_q == ST_CLEAR) ? clr_q : word_s1;
	assign wr_data = (state_q == ST_CLEAR) ? '0 : set_word;

	assign busy = (state_q != ST_IDLE);
	assign fin  = fin_q;
	assign res  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			clr_cmd_q  <= 1'b0;
			fin_q      <= 1'b0;
			res_q      <= '0;
			valid_s1   <= 1'b0;
			wr_valid_q <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			fin_q      <= fin_nxt;
			valid_s1   <= (state_q == ST_WALK);
			wr_valid_q <= valid_s1 && is_mark;
			if (state_q == ST_BASE) begin
				hit_q <= 1'b0;
			end else if (hit_now) begin
				hit_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						res_q.done_operation <= cmd.operation;
						res_q.rejected       <= (cmd.operation == OP_CLASSIFY)
							&& cmd.tile_animated;
						unique case (cmd.operation)
							OP_MARK: begin
								if (cmd.tile_animated) begin
									state_q <= ST_PREP;
								end
							end
							OP_CLASSIFY: begin
								if (!cmd.tile_animated) begin
									state_q <= ST_PREP;
								end
							end
							OP_CLEAR: begin
								state_q   <= ST_CLEAR;
								clr_q     <= '0;
								clr_cmd_q <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PREP: begin
					state_q <= ST_CLIP;
				end
				ST_CLIP: begin
					if (clip_empty) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (x_last && y_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					res_q.rejected <= !is_mark && (hit_q || hit_now);
					state_q        <= ST_IDLE;
				end
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q   <= ST_IDLE;
						clr_cmd_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_PREP) begin
			x0_q <= div8(cmd_q.tile_left);
			y0_q <= div8(cmd_q.tile_top);
		end
		if (state_q == ST_CLIP) begin
			xs_q <= DIM_W'(xs_c);
			xe_q <= DIM_W'(xe_c);
			ys_q <= DIM_W'(ys_c);
			ye_q <= DIM_W'(ye_c);
		end
		if (state_q == ST_BASE) begin
			base_q <= IDX_W'(ys_q) * IDX_W'(mw);
			x_q    <= xs_q;
			y_q    <= ys_q;
		end
		if (state_q == ST_WALK) begin
			if (x_last) begin
				x_q    <= xs_q;
				y_q    <= y_nxt;
				base_q <= base_q + IDX_W'(mw);
			end else begin
				x_q <= x_nxt;
			end
		end
		word_s1   <= idx[IDX_W-1:OFS_W];
		bit_s1    <= idx[OFS_W-1:0];
		wr_addr_q <= word_s1;
		wr_data_q <= set_word;
	end

endmodule

// ===== hw/rtl/animated_square_bitmap_marker_core.sv =====
// ----------------------------------------------------------------------------
// animated_square_bitmap_marker_core: per-square animation bitmap of a map
// Marks squares under animated tiles, classifies tiles, clears the bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: raise start with a cmd beat while busy is low; the beat
//   is taken at that edge. busy stays high until the command has finished.
//   Result channel: done is high for exactly one cycle with the result beat;
//   the receiver cannot stall, so sample result whenever done is high.
//   Configuration: cfg_we/cfg_index/cfg_wdata write map width (index 0) and
//   height (index 1) in squares; write only while idle, then clear the map.
// Timing (edges from the accepting edge to the edge that raises done):
//   mark of a static tile, classify of an animated tile, unused code: 1.
//   tile clipped away entirely: 3.
//   other mark/classify: N + 5, N the number of covered in-map squares; the
//   walk handles one square per cycle through the single bitmap read port.
//   clear: DEPTH + 1 = MAX_WIDTH_SQUARES*MAX_HEIGHT_SQUARES/64 words + 1, one
//   memory word written per cycle.
// Reset: busy comes up high while a clearing pass writes all DEPTH words of
//   the bitmap (DEPTH cycles); no done beat follows it. Map size resets to 128.
// ----------------------------------------------------------------------------
module animated_square_bitmap_marker_core #(
	parameter int MAX_WIDTH_SQUARES  = asbm_pkg::DEF_MAX_WIDTH_SQUARES,
	parameter int MAX_HEIGHT_SQUARES = asbm_pkg::DEF_MAX_HEIGHT_SQUARES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  asbm_pkg::cmd_t                     cmd,
	output logic                               done,
	output asbm_pkg::result_t                  result,
	input  logic                               cfg_we,
	input  logic [asbm_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [asbm_pkg::CFG_W-1:0]         cfg_wdata
);
	import asbm_pkg::*;

	// Bitmap geometry: squares packed linearly, WORD_BITS per memory word
	localparam int TOTAL  = MAX_WIDTH_SQUARES * MAX_HEIGHT_SQUARES;
	localparam int DEPTH  = (TOTAL + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CFG_W-1:0]     map_width_q;
	logic [CFG_W-1:0]     map_height_q;

	logic                 rd_en, wr_en;
	logic [ADDR_W-1:0]    rd_addr, wr_addr;
	logic [WORD_BITS-1:0] rd_data, wr_data;

	// Configuration registers: latch on write enable, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= CFG_SIZE_RESET;
			map_height_q <= CFG_SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAP_WIDTH:  map_width_q  <= cfg_wdata;
				REG_MAP_HEIGHT: map_height_q <= cfg_wdata;
				default: begin
					map_width_q <= map_width_q;
				end
			endcase
		end
	end

	// Sequencer: clip, walk squares, sweep on clear; owns the result register
	asbm_walker #(
		.MAX_W  (MAX_WIDTH_SQUARES),
		.MAX_H  (MAX_HEIGHT_SQUARES),
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.map_width  (map_width_q),
		.map_height (map_height_q),
		.busy       (busy),
		.fin        (done),
		.res        (result),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	// Bitmap words
	asbm_bitmap_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.WORD_W (WORD_BITS)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

`ifndef NO_ASSERTIONS
	// A done beat only leaves once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done beat while busy");

	// Every accepted command either finishes at once or holds busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command dropped");

	// A done beat follows an accepted command or busy work
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("spurious done beat");

	// Only classify can reject
	a_reject_classify: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.done_operation != OP_CLASSIFY)) |-> !result.rejected)
		else $error("rejected set outside classify");
`endif

endmodule
